### hw/rtl/pin_lock_controller_defines.svh
// assertion macros for the pin lock controller rtl
`ifndef PIN_LOCK_CONTROLLER_DEFINES_SVH
`define PIN_LOCK_CONTROLLER_DEFINES_SVH

// clocked assertion, masked while reset is held
`define PLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also checks reset behavior
`define PLC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/plc_pkg.sv
// types, codes and helpers for the pin lock controller
`default_nettype none

package plc_pkg;

    // command bytes seen in idle
    localparam logic [7:0] CMD_OPEN   = 8'd111;
    localparam logic [7:0] CMD_CHANGE = 8'd109;
    localparam logic [7:0] CMD_CLOSE  = 8'd102;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] TIMEOUT_DIGIT = 8'd0;

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    // word kind on the input tuser bit
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // entry phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_OPEN = 5'b00010,
        PH_CUR  = 5'b00100,
        PH_NEW  = 5'b01000,
        PH_CONF = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        MOTOR_NONE  = 2'd0,
        MOTOR_OPEN  = 2'd1,
        MOTOR_CLOSE = 2'd2
    } t_motor;

    typedef enum logic [2:0] {
        ST_NONE           = 3'd0,
        ST_PIN_PROMPT     = 3'd1,
        ST_WRONG_PIN      = 3'd2,
        ST_UNLOCKED       = 3'd3,
        ST_MISMATCH       = 3'd4,
        ST_CHANGED        = 3'd5,
        ST_NEW_PROMPT     = 3'd6,
        ST_CONFIRM_PROMPT = 3'd7
    } t_status;

    // binary phase codes reported on the output
    localparam logic [2:0] PC_IDLE = 3'd0;
    localparam logic [2:0] PC_OPEN = 3'd1;
    localparam logic [2:0] PC_CUR  = 3'd2;
    localparam logic [2:0] PC_NEW  = 3'd3;
    localparam logic [2:0] PC_CONF = 3'd4;

    typedef struct packed {
        t_motor     motor;
        t_status    status;
        logic       door;
        logic [2:0] phase;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        code = PC_IDLE;
        unique case (ph)
            PH_IDLE: code = PC_IDLE;
            PH_OPEN: code = PC_OPEN;
            PH_CUR:  code = PC_CUR;
            PH_NEW:  code = PC_NEW;
            PH_CONF: code = PC_CONF;
            default: code = PC_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/plc_core.sv
// lock state, pin stores and the per-word transition logic
`default_nettype none

module plc_core #(
    parameter int PIN_DIGITS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_op,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [15:0]      i_cfg_wr_data,
    output plc_pkg::t_result      o_result
);
    import plc_pkg::*;

    localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIN_DIGITS - 1);

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_match, n_match;
    logic [15:0]      r_wait, n_wait;
    logic             r_door, n_door;
    logic [15:0]      r_limit;
    logic [7:0]       r_stored [PIN_DIGITS];
    logic [7:0]       r_entry  [PIN_DIGITS];

    logic       take;
    logic       entry_we;
    logic       store_we;
    logic [7:0] digit;
    logic       digit_ok;
    logic       match_all;
    t_motor     motor;
    t_status    status;

    assign digit = (i_op == OP_BYTE) ? i_byte : TIMEOUT_DIGIT;

    // next state and result for the presented word
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_match   = r_match;
        n_wait    = r_wait;
        n_door    = r_door;
        motor     = MOTOR_NONE;
        status    = ST_NONE;
        take      = 1'b0;
        entry_we  = 1'b0;
        store_we  = 1'b0;
        digit_ok  = 1'b1;
        match_all = r_match;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_op == OP_BYTE) begin
                    if (i_byte == CMD_OPEN || i_byte == CMD_CHANGE) begin
                        n_phase = (i_byte == CMD_OPEN) ? PH_OPEN : PH_CUR;
                        n_idx   = '0;
                        n_match = 1'b1;
                        status  = ST_PIN_PROMPT;
                    end else if (i_byte == CMD_CLOSE && r_door) begin
                        motor  = MOTOR_CLOSE;
                        n_door = 1'b0;
                    end
                end
                n_wait = '0;
            end
            PH_OPEN, PH_CUR, PH_NEW, PH_CONF: begin
                if (i_op == OP_BYTE || r_wait >= r_limit) begin
                    take = 1'b1;
                end else begin
                    n_wait = r_wait + 16'd1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_idx   = '0;
                n_match = 1'b1;
                n_wait  = '0;
            end
        endcase

        // one digit taken in an entry phase
        if (take) begin
            n_wait = '0;
            priority case (r_phase)
                PH_OPEN, PH_CUR: digit_ok = (digit == r_stored[r_idx]);
                PH_CONF:         digit_ok = (digit == r_entry[r_idx]);
                default: begin
                    digit_ok = 1'b1;
                    entry_we = 1'b1;
                end
            endcase
            match_all = r_match & digit_ok;
            if (r_idx != LAST_IDX) begin
                n_idx   = r_idx + IDX_W'(1);
                n_match = match_all;
            end else begin
                n_idx   = '0;
                n_match = 1'b1;
                priority case (r_phase)
                    PH_OPEN: begin
                        n_phase = PH_IDLE;
                        if (match_all) begin
                            status = ST_UNLOCKED;
                            if (!r_door) begin
                                motor  = MOTOR_OPEN;
                                n_door = 1'b1;
                            end
                        end else begin
                            status = ST_WRONG_PIN;
                        end
                    end
                    PH_CUR: begin
                        if (match_all) begin
                            n_phase = PH_NEW;
                            status  = ST_NEW_PROMPT;
                        end else begin
                            n_phase = PH_IDLE;
                            status  = ST_WRONG_PIN;
                        end
                    end
                    PH_NEW: begin
                        n_phase = PH_CONF;
                        status  = ST_CONFIRM_PROMPT;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (match_all) begin
                            store_we = 1'b1;
                            status   = ST_CHANGED;
                        end else begin
                            status = ST_MISMATCH;
                        end
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_match <= 1'b1;
            r_wait  <= '0;
            r_door  <= 1'b1;
            r_limit <= TIMEOUT_RESET;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_match <= n_match;
                r_wait  <= n_wait;
                r_door  <= n_door;
            end
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // stored pin, copied from the new-pin buffer on a confirmed change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIN_DIGITS; k++) begin
                r_stored[k] <= ASCII_ZERO;
            end
        end else if (i_accept && store_we) begin
            for (int k = 0; k < PIN_DIGITS; k++) begin
                r_stored[k] <= r_entry[k];
            end
        end
    end

    // new-pin buffer, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && entry_we) begin
            r_entry[r_idx] <= digit;
        end
    end

    assign o_result.motor  = motor;
    assign o_result.status = status;
    assign o_result.door   = n_door;
    assign o_result.phase  = phase_code(n_phase);

endmodule

`default_nettype wire

### hw/rtl/pin_lock_controller.sv
// top level of the pin lock controller: stream ports and result register
//
// Input stream carries one word per received byte or timer tick: tuser is the
// kind (0 byte, 1 tick), tdata the byte. Each accepted word yields exactly one
// result word on the output stream: bolt drive, status code, door state and
// entry phase after that word.
// One register stage: a word accepted at an edge shows its result at the
// output from that edge on. Throughput: one word per cycle unless the
// output stalls; the state update is a single transition with one digit
// compare per word. The result register frees the input side: a new word is
// taken whenever the register is empty or its word is taken in the same
// cycle. While the output is stalled with a word held, input tready stays
// low and the held word stays unchanged.
// The user must write the timeout limit (i_cfg_wr_en / i_cfg_wr_data) while the
// block is idle; the block does not enforce it. It takes effect for the next word.
// Reset (synchronous, active low) returns to idle with the door open, the
// stored pin set to ASCII '0000', timeout limit 200 and the output empty.
`default_nettype none

module pin_lock_controller #(
    parameter int PIN_DIGITS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  wire logic        i_s_axis_tuser,   // [0] op
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [1:0] motor_cmd, [4:2] status,
                                               // [5] door_is_open, [8:6] entry_phase
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);
    import plc_pkg::*;

    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    // take a word when the result register can hold its result
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    plc_core #(
        .PIN_DIGITS(PIN_DIGITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_s_axis_tuser),
        .i_byte        (i_s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.phase, r_out.door, r_out.status, r_out.motor};

`include "pin_lock_controller_defines.svh"

    `PLC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `PLC_ASSERT(a_open_unlocked, r_out_valid && r_out.motor == MOTOR_OPEN |-> r_out.status == ST_UNLOCKED && r_out.door, "bolt open without unlock")
    `PLC_ASSERT(a_close_door, r_out_valid && r_out.motor == MOTOR_CLOSE |-> !r_out.door && r_out.phase == PC_IDLE, "bolt close with door left open")
    `PLC_ASSERT(a_no_drop, r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out), "held result lost")

endmodule

`default_nettype wire

### tb/pin_lock_controller_tb.sv
// self-checking testbench for the pin lock controller: directed flows, timeouts, random traffic
`default_nettype none

module pin_lock_controller_tb;
    import plc_pkg::*;

    localparam int NDIG        = 4;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;    // [7:0] byte_value
    logic        i_s_axis_tuser = 1'b0;    // [0] op
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // [1:0] motor_cmd, [4:2] status,
                                           // [5] door_is_open, [8:6] entry_phase
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = 16'd0;

    pin_lock_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // lock state as the testbench tracks it
    logic [2:0]  lk_phase;
    logic [1:0]  lk_idx;
    logic [7:0]  lk_stored [NDIG];
    logic [7:0]  lk_entry [NDIG];
    logic        lk_match;
    logic [15:0] lk_wait;
    logic        lk_door;
    logic [15:0] lk_limit;

    t_result     outcome_q [$];
    t_result     want;
    int          errors = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          pins_changed = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles;

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // output side back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void lock_begin(input logic [2:0] ph);
        lk_phase = ph;
        lk_idx   = 2'd0;
        lk_match = 1'b1;
        lk_wait  = 16'd0;
    endfunction

    // next lock state and the result word for one input word
    function automatic t_result lock_advance(input logic op, input logic [7:0] b);
        t_result    r;
        logic       take;
        logic [7:0] d;
        r.motor  = MOTOR_NONE;
        r.status = ST_NONE;
        take     = 1'b0;
        d        = b;
        if (lk_phase == PC_IDLE) begin
            if (op == OP_BYTE) begin
                if (b == CMD_OPEN) begin
                    lock_begin(PC_OPEN);
                    r.status = ST_PIN_PROMPT;
                end else if (b == CMD_CHANGE) begin
                    lock_begin(PC_CUR);
                    r.status = ST_PIN_PROMPT;
                end else if (b == CMD_CLOSE && lk_door) begin
                    r.motor = MOTOR_CLOSE;
                    lk_door = 1'b0;
                end
            end
            lk_wait = 16'd0;
        end else if (op == OP_BYTE) begin
            take = 1'b1;
        end else if (lk_wait >= lk_limit) begin
            take = 1'b1;
            d    = TIMEOUT_DIGIT;
        end else begin
            lk_wait = lk_wait + 16'd1;
        end

        if (take) begin
            case (lk_phase)
                PC_OPEN, PC_CUR: if (d != lk_stored[lk_idx]) lk_match = 1'b0;
                PC_NEW:          lk_entry[lk_idx] = d;
                default:         if (d != lk_entry[lk_idx]) lk_match = 1'b0;
            endcase
            lk_wait = 16'd0;
            if (lk_idx != NDIG - 1) begin
                lk_idx = lk_idx + 2'd1;
            end else begin
                lk_idx = 2'd0;
                case (lk_phase)
                    PC_OPEN: begin
                        if (lk_match) begin
                            r.status = ST_UNLOCKED;
                            if (!lk_door) begin
                                r.motor = MOTOR_OPEN;
                                lk_door = 1'b1;
                            end
                        end else begin
                            r.status = ST_WRONG_PIN;
                        end
                        lk_phase = PC_IDLE;
                    end
                    PC_CUR: begin
                        if (lk_match) begin
                            lock_begin(PC_NEW);
                            r.status = ST_NEW_PROMPT;
                        end else begin
                            r.status = ST_WRONG_PIN;
                            lk_phase = PC_IDLE;
                        end
                    end
                    PC_NEW: begin
                        lock_begin(PC_CONF);
                        r.status = ST_CONFIRM_PROMPT;
                    end
                    default: begin
                        if (lk_match) begin
                            for (int k = 0; k < NDIG; k++) lk_stored[k] = lk_entry[k];
                            r.status = ST_CHANGED;
                        end else begin
                            r.status = ST_MISMATCH;
                        end
                        lk_phase = PC_IDLE;
                    end
                endcase
                lk_match = 1'b1;
            end
        end
        r.door  = lk_door;
        r.phase = lk_phase;
        return r;
    endfunction

    // send one word; called at a rising edge, returns at the edge that takes it
    task automatic send_word(input logic op, input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= op;
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
        outcome_q.push_back(lock_advance(op, b));
        words_sent++;
    endtask

    // drop valid and wait until every result has come back
    task automatic settle;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        lk_limit = v;
    endtask

    // one digit, sometimes preceded by ticks; with a small limit the ticks may time out
    task automatic send_digit(input logic [7:0] d);
        int n;
        if ($urandom_range(99) < 30) begin
            n = (lk_limit <= 16'd6) ? $urandom_range(int'(lk_limit) + 1) : $urandom_range(2);
            repeat (n) send_word(OP_TICK, 8'($urandom_range(255)));
        end
        send_word(OP_BYTE, d);
    endtask

    // four digits, lowest byte first
    task automatic send_code(input logic [31:0] code);
        for (int k = 0; k < NDIG; k++) send_digit(code[8*k +: 8]);
    endtask

    function automatic logic [31:0] stored_code();
        return {lk_stored[3], lk_stored[2], lk_stored[1], lk_stored[0]};
    endfunction

    function automatic logic [31:0] random_code();
        logic [31:0] c;
        for (int k = 0; k < NDIG; k++) begin
            if ($urandom_range(99) < 70) c[8*k +: 8] = 8'(ASCII_ZERO + $urandom_range(9));
            else c[8*k +: 8] = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [31:0] spoil_code(input logic [31:0] c);
        logic [7:0] flip;
        int         k;
        flip = 8'($urandom_range(1, 255));
        k    = $urandom_range(NDIG - 1);
        c[8*k +: 8] = c[8*k +: 8] ^ flip;
        return c;
    endfunction

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
        end
    endtask

    // compare each result word taken at the next edge with the oldest prediction
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
                errors++;
                $display("%0t: result word %h expected none got one", $time, o_m_axis_tdata);
            end else begin
                want = outcome_q.pop_front();
                if (want.status == ST_CHANGED) pins_changed++;
                check_field("motor_cmd", int'(want.motor), int'(o_m_axis_tdata[1:0]));
                check_field("status", int'(want.status), int'(o_m_axis_tdata[4:2]));
                check_field("door_is_open", int'(want.door), int'(o_m_axis_tdata[5]));
                check_field("entry_phase", int'(want.phase), int'(o_m_axis_tdata[8:6]));
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(negedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog, no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("pin_lock_controller_tb: done, errors");
        $finish;
    end

    // open, close, ignored words and commands taken as digits
    task automatic test_idle_commands;
        // correct pin with the door already open
        send_word(OP_BYTE, CMD_OPEN);
        send_code({4{ASCII_ZERO}});
        send_word(OP_BYTE, CMD_CLOSE);
        // close again does nothing
        send_word(OP_BYTE, CMD_CLOSE);
        // command bytes inside an entry count as digits
        send_word(OP_BYTE, CMD_OPEN);
        send_code({8'h00, 8'hFF, CMD_CLOSE, CMD_CHANGE});
        send_word(OP_BYTE, CMD_OPEN);
        send_code({4{ASCII_ZERO}});
        // ignored in idle
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_TICK, 8'hAA);
    endtask

    // change the pin to one holding a zero byte
    task automatic test_pin_change;
        send_word(OP_BYTE, CMD_CHANGE);
        send_code({4{ASCII_ZERO}});
        send_code({ASCII_ZERO + 8'd1, CMD_OPEN, 8'h00, 8'hFF});
        send_code({ASCII_ZERO + 8'd1, CMD_OPEN, 8'h00, 8'hFF});
    endtask

    // a timed-out slot enters the zero digit
    task automatic test_digit_timeout;
        set_timeout(16'd1);
        send_word(OP_BYTE, CMD_CLOSE);
        send_word(OP_BYTE, CMD_OPEN);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_TICK, 8'h55);
        send_word(OP_TICK, 8'h00);
        send_word(OP_BYTE, CMD_OPEN);
        send_word(OP_BYTE, ASCII_ZERO + 8'd1);
    endtask

    // longer limit: the wait counter climbs tick by tick before the first slot times out
    task automatic test_timeout_extremes;
        set_timeout(16'd20);
        send_word(OP_BYTE, CMD_OPEN);
        repeat (21) send_word(OP_TICK, 8'($urandom_range(255)));
        for (int k = 1; k < NDIG; k++) send_word(OP_BYTE, lk_stored[k]);
        set_timeout(TIMEOUT_RESET);
    endtask

    // well-formed flows with random content, broken entries and noise
    task automatic run_traffic(input int idle, input int stall, input logic [15:0] limit,
                               input int n);
        int          stop_at;
        int          pick;
        logic [31:0] code;
        set_timeout(limit);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                code = stored_code();
                if ($urandom_range(99) < 30) code = spoil_code(code);
                send_word(OP_BYTE, CMD_OPEN);
                send_code(code);
            end else if (pick < 45) begin
                send_word(OP_BYTE, CMD_CLOSE);
            end else if (pick < 70) begin
                code = stored_code();
                if ($urandom_range(99) < 25) code = spoil_code(code);
                send_word(OP_BYTE, CMD_CHANGE);
                send_code(code);
                code = random_code();
                send_code(code);
                if ($urandom_range(99) < 30) code = spoil_code(code);
                send_code(code);
            end else if (pick < 80) begin
                // entry cut short; what follows is taken as digits
                send_word(OP_BYTE, ($urandom_range(1) != 0) ? CMD_OPEN : CMD_CHANGE);
                repeat ($urandom_range(1, 3)) send_digit(8'(ASCII_ZERO + $urandom_range(9)));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        lk_phase = PC_IDLE;
        lk_idx   = 2'd0;
        lk_match = 1'b1;
        lk_wait  = 16'd0;
        lk_door  = 1'b1;
        lk_limit = TIMEOUT_RESET;
        for (int k = 0; k < NDIG; k++) begin
            lk_stored[k] = ASCII_ZERO;
            lk_entry[k]  = 8'd0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_pin_change();
        test_digit_timeout();
        test_timeout_extremes();
        run_traffic(0, 0, 16'd1, 150);
        run_traffic(65, 0, 16'($urandom_range(2, 5)), 150);
        run_traffic(0, 65, 16'hFFFF, 150);
        run_traffic(37, 37, TIMEOUT_RESET, 150);
        settle();

        $display("covered %0d words, %0d results checked, %0d pin changes accepted",
                 words_sent, results_seen, pins_changed);
        $display("flows: open, close, pin change, cut entries, timeout limits from 1 to 65535");
        if (errors == 0)
            $display("pin_lock_controller_tb: done, clean");
        else
            $display("pin_lock_controller_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
